/* hw/rtl/ckt_pkg.sv */
// Shared constants, codes and types of the counted key table.
package ckt_pkg;

  localparam int DEPTH       = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int COUNT_WIDTH = 32;

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = KEY_WIDTH + COUNT_WIDTH;

  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int KEY_PORT_W   = 32;
  localparam int COUNT_PORT_W = 32;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  localparam logic [REQ_W-1:0] REQ_INC   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEC   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LIST  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

  localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STS_SATURATED = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_MOVE = 4'b0100,
    S_LIST = 4'b1000
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [KEY_WIDTH-1:0]   key;
    logic [COUNT_WIDTH-1:0] count;
    logic                   valid;
    logic                   last;
  } result_t;

  function automatic result_t mk_res(logic [STATUS_W-1:0] status,
                                     logic [KEY_WIDTH-1:0] key,
                                     logic [COUNT_WIDTH-1:0] count,
                                     logic valid, logic last);
    result_t r;
    r.status = status;
    r.key    = key;
    r.count  = count;
    r.valid  = valid;
    r.last   = last;
    return r;
  endfunction

endpackage

/* hw/rtl/ckt_ram.sv */
// Generic simple dual-port RAM with registered read.
module ckt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/counted_key_table.sv */
// Counted key table: packed (key, count) store with scan sequencer.
//
//  channel  ports                                    transfer when
//  in       start, busy, in_req_type, in_activity_key start & !busy
//  out      out_strobe, out_status, out_entry_*, out_last  out_strobe
//
// Increment/decrement scan the RAM one entry per cycle until a hit or past the
// last entry; a removal then reads the last entry to fill the hole. List
// returns one result per cycle. Clear and list of an empty table finish at the
// accept edge without going busy. The result is registered: it appears in the
// cycle after its decision. Reset empties the table; the RAM is not cleared.
// The receiver cannot stall the result channel.
module counted_key_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [ckt_pkg::REQ_W-1:0]         in_req_type,
  input  logic [ckt_pkg::KEY_PORT_W-1:0]    in_activity_key,
  output logic                              out_strobe,
  output logic [ckt_pkg::STATUS_W-1:0]      out_status,
  output logic [ckt_pkg::KEY_PORT_W-1:0]    out_entry_key,
  output logic [ckt_pkg::COUNT_PORT_W-1:0]  out_entry_count,
  output logic                              out_entry_valid,
  output logic                              out_last
);
  import ckt_pkg::*;

  state_t               state_r, state_nxt;
  logic [OCC_W-1:0]     occ_r, occ_nxt;
  logic [OCC_W-1:0]     issue_r, issue_nxt;
  logic                 pend_r, pend_nxt;
  logic [ADDR_W-1:0]    pidx_r, pidx_nxt;
  logic [ADDR_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic [REQ_W-1:0]     req_r, req_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic                 strobe_r, strobe_nxt;
  result_t              res_r, res_nxt;

  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [ENTRY_W-1:0]     wr_data;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ENTRY_W-1:0]     rd_data;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic [OCC_W-1:0]       occ_m1;
  logic [ADDR_W-1:0]      last_idx;
  logic                   accept;

  ckt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_key   = rd_data[ENTRY_W-1 -: KEY_WIDTH];
  assign rd_cnt   = rd_data[COUNT_WIDTH-1:0];
  assign occ_m1   = occ_r - OCC_W'(1);
  assign last_idx = occ_m1[ADDR_W-1:0];
  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;

  always_comb begin
    state_nxt   = state_r;
    occ_nxt     = occ_r;
    issue_nxt   = issue_r;
    pend_nxt    = 1'b0;
    pidx_nxt    = issue_r[ADDR_W-1:0];
    hit_idx_nxt = hit_idx_r;
    req_nxt     = req_r;
    key_nxt     = key_r;
    strobe_nxt  = 1'b0;
    res_nxt     = res_r;
    wr_en       = 1'b0;
    wr_addr     = pidx_r;
    wr_data     = {key_r, rd_cnt};
    rd_addr     = issue_r[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_req_type;
          key_nxt   = KEY_WIDTH'(in_activity_key);
          issue_nxt = '0;
          unique case (in_req_type)
            REQ_CLEAR: begin
              occ_nxt    = '0;
              strobe_nxt = 1'b1;
              res_nxt    = mk_res(STS_OK, '0, '0, 1'b0, 1'b1);
            end
            REQ_LIST: begin
              if (occ_r == '0) begin
                strobe_nxt = 1'b1;
                res_nxt    = mk_res(STS_OK, '0, '0, 1'b0, 1'b1);
              end else begin
                state_nxt = S_LIST;
              end
            end
            REQ_INC, REQ_DEC: begin
              state_nxt = S_SCAN;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        // keep one read in flight ahead of the compare
        if (issue_r < occ_r) begin
          pend_nxt  = 1'b1;
          issue_nxt = issue_r + OCC_W'(1);
        end
        if (pend_r && rd_key == key_r) begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          if (req_r == REQ_INC) begin
            if (rd_cnt == CNT_MAX) begin
              res_nxt = mk_res(STS_SATURATED, key_r, rd_cnt, 1'b1, 1'b1);
            end else begin
              wr_en   = 1'b1;
              wr_data = {key_r, rd_cnt + CNT_ONE};
              res_nxt = mk_res(STS_OK, key_r, rd_cnt + CNT_ONE, 1'b1, 1'b1);
            end
          end else if (rd_cnt == CNT_ONE) begin
            // removal: fetch the last entry to fill the hole
            strobe_nxt  = 1'b0;
            hit_idx_nxt = pidx_r;
            rd_addr     = last_idx;
            state_nxt   = S_MOVE;
          end else begin
            wr_en   = 1'b1;
            wr_data = {key_r, rd_cnt - CNT_ONE};
            res_nxt = mk_res(STS_OK, key_r, rd_cnt - CNT_ONE, 1'b1, 1'b1);
          end
        end else if (!pend_r && issue_r >= occ_r) begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          if (req_r == REQ_INC) begin
            if (occ_r < OCC_W'(DEPTH)) begin
              wr_en   = 1'b1;
              wr_addr = occ_r[ADDR_W-1:0];
              wr_data = {key_r, CNT_ONE};
              occ_nxt = occ_r + OCC_W'(1);
              res_nxt = mk_res(STS_OK, key_r, CNT_ONE, 1'b1, 1'b1);
            end else begin
              res_nxt = mk_res(STS_FULL, key_r, '0, 1'b0, 1'b1);
            end
          end else begin
            res_nxt = mk_res(STS_NOT_FOUND, key_r, '0, 1'b0, 1'b1);
          end
        end
      end

      S_MOVE: begin
        wr_en      = 1'b1;
        wr_addr    = hit_idx_r;
        wr_data    = rd_data;
        occ_nxt    = occ_m1;
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        res_nxt    = mk_res(STS_OK, key_r, '0, 1'b1, 1'b1);
      end

      S_LIST: begin
        if (issue_r < occ_r) begin
          pend_nxt  = 1'b1;
          issue_nxt = issue_r + OCC_W'(1);
        end
        if (pend_r) begin
          strobe_nxt = 1'b1;
          res_nxt    = mk_res(STS_OK, rd_key, rd_cnt, 1'b1, pidx_r == last_idx);
          if (pidx_r == last_idx) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      occ_r    <= '0;
      issue_r  <= '0;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      issue_r  <= issue_nxt;
      pend_r   <= pend_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r    <= pidx_nxt;
    hit_idx_r <= hit_idx_nxt;
    req_r     <= req_nxt;
    key_r     <= key_nxt;
    res_r     <= res_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_status      = res_r.status;
  assign out_entry_key   = KEY_PORT_W'(res_r.key);
  assign out_entry_count = COUNT_PORT_W'(res_r.count);
  assign out_entry_valid = res_r.valid;
  assign out_last        = res_r.last;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("occupancy beyond table depth");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && res_r.last) |-> !busy)
    else $error("final result while still busy");

  a_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && !res_r.last) |-> (state_r == S_LIST))
    else $error("non-final result outside a list");

  a_no_idle_wr: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r != S_IDLE))
    else $error("table write while idle");

  a_accept_acts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || strobe_r))
    else $error("accepted item neither worked on nor answered");

endmodule
